FILE: hdl/kwsrm_pkg.sv
// Shared types and codes for the k-way sorted run merger.
// Used by kwsrm_front, kwsrm_queue and kway_sorted_run_merger_top.
package kwsrm_pkg;

  localparam int KEY_W    = 64;
  localparam int OFF_W    = 48;
  localparam int RUN_W    = 3;
  localparam int CFG_W    = 4;
  localparam int RUNS_RST = 2;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  typedef enum logic [1:0] {
    ST_RECORD = 2'd0,
    ST_DONE   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic {
    ACT_RECORD  = 1'b0,
    ACT_EXHAUST = 1'b1
  } action_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   out_key;
    logic [OFF_W-1:0]   out_offset;
    logic [RUN_W-1:0]   source_run;
  } result_t;

  // engine status seen by the top level
  typedef struct packed {
    logic               any_state;   // some head full or run exhausted
    logic [RUN_W:0]     count_lo;    // effective run count, low bits
  } eng_stat_t;

endpackage

FILE: hdl/kwsrm_front.sv
// Front part of the merger: accepts and classifies input beats, keeps the
// per-run heads and selects the smallest head. Depends on kwsrm_pkg.
module kwsrm_front #(
  parameter int MAX_RUNS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [kwsrm_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  input  logic                         space,
  input  kwsrm_pkg::action_t           action,
  input  logic [kwsrm_pkg::RUN_W-1:0]  run,
  input  logic [kwsrm_pkg::KEY_W-1:0]  record_key,
  input  logic [kwsrm_pkg::OFF_W-1:0]  record_offset,
  output logic                         push,
  output kwsrm_pkg::result_t           push_res,
  output kwsrm_pkg::eng_stat_t         stat
);

  localparam int IW  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CW  = $clog2(MAX_RUNS + 1);
  localparam int W   = (CW > kwsrm_pkg::CFG_W) ? CW : kwsrm_pkg::CFG_W;
  localparam int P   = 1 << IW;
  localparam int NN  = 2 * P - 1;

  logic [kwsrm_pkg::CFG_W-1:0] runs_in_use;
  logic [kwsrm_pkg::KEY_W-1:0] head_key [MAX_RUNS];
  logic [kwsrm_pkg::OFF_W-1:0] head_offset [MAX_RUNS];
  logic [MAX_RUNS-1:0]         head_full, head_full_next;
  logic [MAX_RUNS-1:0]         run_exhausted, run_exhausted_next;

  logic [W-1:0]                cfg_w, count, run_w;
  logic [IW-1:0]               idx;
  logic                        accept, reject, ready_all, wr_rec;
  logic [MAX_RUNS-1:0]         act, full_upd, exh_upd;

  logic                        nv [NN];
  logic [kwsrm_pkg::KEY_W-1:0] nk [NN];
  logic [kwsrm_pkg::OFF_W-1:0] no [NN];
  logic [IW-1:0]               ni [NN];

  assign accept = in_valid && space;
  assign cfg_w  = W'(runs_in_use);
  assign run_w  = W'(run);
  assign idx    = run_w[IW-1:0];

  always_comb begin
    if (cfg_w == '0) begin
      count = W'(1);
    end else if (cfg_w > W'(MAX_RUNS)) begin
      count = W'(MAX_RUNS);
    end else begin
      count = cfg_w;
    end
  end

  assign reject = (run_w >= count) || head_full[idx] || run_exhausted[idx];
  assign wr_rec = (action == kwsrm_pkg::ACT_RECORD);

  always_comb begin
    for (int i = 0; i < MAX_RUNS; i++) begin
      act[i]      = W'(i) < count;
      full_upd[i] = head_full[i] || (wr_rec && idx == IW'(i));
      exh_upd[i]  = run_exhausted[i] || (!wr_rec && idx == IW'(i));
    end
  end

  always_comb begin
    ready_all = 1'b1;
    for (int i = 0; i < MAX_RUNS; i++) begin
      if (act[i] && !full_upd[i] && !exh_upd[i]) begin
        ready_all = 1'b0;
      end
    end
  end

  // Min tree over the heads as they stand after this beat; left child holds
  // the lower run indexes, so it wins ties.
  always_comb begin
    for (int i = 0; i < P; i++) begin
      if (i < MAX_RUNS) begin
        nv[P-1+i] = act[i] && full_upd[i];
        nk[P-1+i] = (wr_rec && idx == IW'(i)) ? record_key : head_key[i];
        no[P-1+i] = (wr_rec && idx == IW'(i)) ? record_offset : head_offset[i];
      end else begin
        nv[P-1+i] = 1'b0;
        nk[P-1+i] = '0;
        no[P-1+i] = '0;
      end
      ni[P-1+i] = IW'(i);
    end
    for (int n = P - 2; n >= 0; n--) begin
      if (nv[2*n+2] && (!nv[2*n+1] || nk[2*n+2] < nk[2*n+1] ||
          (nk[2*n+2] == nk[2*n+1] && no[2*n+2] < no[2*n+1]))) begin
        nv[n] = 1'b1;
        nk[n] = nk[2*n+2];
        no[n] = no[2*n+2];
        ni[n] = ni[2*n+2];
      end else begin
        nv[n] = nv[2*n+1];
        nk[n] = nk[2*n+1];
        no[n] = no[2*n+1];
        ni[n] = ni[2*n+1];
      end
    end
  end

  always_comb begin
    head_full_next     = head_full;
    run_exhausted_next = run_exhausted;
    push               = 1'b0;
    push_res           = '0;
    if (accept) begin
      if (reject) begin
        push            = 1'b1;
        push_res.status = kwsrm_pkg::ST_REJECT;
      end else begin
        head_full_next     = full_upd;
        run_exhausted_next = exh_upd;
        if (ready_all) begin
          push = 1'b1;
          if (nv[0]) begin
            head_full_next[ni[0]] = 1'b0;
            push_res.status       = kwsrm_pkg::ST_RECORD;
            push_res.out_key      = nk[0];
            push_res.out_offset   = no[0];
            push_res.source_run   = kwsrm_pkg::RUN_W'(ni[0]);
          end else begin
            // merge finished: clear for the next one
            head_full_next     = '0;
            run_exhausted_next = '0;
            push_res.status    = kwsrm_pkg::ST_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      runs_in_use   <= kwsrm_pkg::CFG_W'(kwsrm_pkg::RUNS_RST);
      head_full     <= '0;
      run_exhausted <= '0;
    end else begin
      if (cfg_we) begin
        runs_in_use <= cfg_wdata;
      end
      head_full     <= head_full_next;
      run_exhausted <= run_exhausted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !reject && wr_rec) begin
      head_key[idx]    <= record_key;
      head_offset[idx] <= record_offset;
    end
  end

  assign stat.any_state = (|head_full) || (|run_exhausted);
  assign stat.count_lo  = (kwsrm_pkg::RUN_W+1)'(count);

endmodule

FILE: hdl/kwsrm_queue.sv
// Two-entry result queue between the merge front and the output stream.
// Depends on kwsrm_pkg for the result type and depth.
module kwsrm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  kwsrm_pkg::result_t push_res,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output kwsrm_pkg::result_t out_res
);

  kwsrm_pkg::result_t                mem [kwsrm_pkg::QDEPTH];
  logic [kwsrm_pkg::QPTR_W-1:0]      wr_ptr, rd_ptr;
  logic [kwsrm_pkg::QCNT_W-1:0]      cnt;
  logic                              pop;

  assign space     = cnt != kwsrm_pkg::QCNT_W'(kwsrm_pkg::QDEPTH);
  assign out_valid = cnt != '0;
  assign pop       = out_valid && out_ready;
  assign out_res   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_res;
    end
  end

endmodule

FILE: hdl/kway_sorted_run_merger_top.sv
// K-way merger of sorted runs: one input beat per cycle while the result queue
// has space, as the head update and min tree in kwsrm_front are combinational.
// Each result is registered into the queue and shown on m_tvalid from there.
// A two-entry queue lets the input keep flowing while a result waits.
// Synchronous reset clears head flags, exhausted flags and the queue, and
// sets runs_in_use to 2. Heads hold no reset value.
module kway_sorted_run_merger_top #(
  parameter int MAX_RUNS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_wdata,   // runs_in_use
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [119:0]  s_tdata,     // run[2:0], record_key[66:3], record_offset[114:67]
  input  logic          s_tuser,     // action
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [119:0]  m_tdata,     // out_key[63:0], out_offset[111:64], source_run[114:112]
  output logic [1:0]    m_tuser      // status
);

  logic                  push;
  kwsrm_pkg::result_t    push_res, out_res;
  kwsrm_pkg::eng_stat_t  stat;
  logic                  space;
  kwsrm_pkg::action_t    action;

  assign action   = kwsrm_pkg::action_t'(s_tuser);
  assign s_tready = space;

  kwsrm_front #(.MAX_RUNS(MAX_RUNS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (s_tvalid),
    .space         (space),
    .action        (action),
    .run           (s_tdata[2:0]),
    .record_key    (s_tdata[66:3]),
    .record_offset (s_tdata[114:67]),
    .push          (push),
    .push_res      (push_res),
    .stat          (stat)
  );

  kwsrm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {5'd0, out_res.source_run, out_res.out_offset, out_res.out_key};
  assign m_tuser = out_res.status;

  // no push may land in a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("result pushed into full queue");

  // completion leaves no head or exhausted flag behind
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (push && push_res.status == kwsrm_pkg::ST_DONE) |=> !stat.any_state)
    else $error("merge finished but state not cleared");

  // an emitted record comes from a run in use
  a_src_in_range: assert property (@(posedge clk) disable iff (rst)
    (push && push_res.status == kwsrm_pkg::ST_RECORD) |->
      ({1'b0, push_res.source_run} < stat.count_lo))
    else $error("record emitted from run outside the count");

  // non-record results carry zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (push && push_res.status != kwsrm_pkg::ST_RECORD) |->
      (push_res.out_key == '0 && push_res.out_offset == '0 && push_res.source_run == '0))
    else $error("status result with nonzero fields");

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for kway_sorted_run_merger_top: random and directed
// merge traffic, a shadow merge model, and in-order checks of result beats.
// Depends on kwsrm_pkg and the merger RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NRUNS       = 8;
  localparam int PHASE_BEATS = 160;
  localparam int NPHASES     = 8;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    kwsrm_pkg::action_t                act;
    logic [kwsrm_pkg::RUN_W-1:0]       run;
    logic [kwsrm_pkg::KEY_W-1:0]       key;
    logic [kwsrm_pkg::OFF_W-1:0]       off;
  } merge_beat_t;

  typedef struct packed {
    logic [kwsrm_pkg::CFG_W-1:0]                   runs;
    logic [NRUNS-1:0][kwsrm_pkg::KEY_W-1:0]        hk;
    logic [NRUNS-1:0][kwsrm_pkg::OFF_W-1:0]        ho;
    logic [NRUNS-1:0]                              full;
    logic [NRUNS-1:0]                              exh;
  } merge_state_t;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         cfg_we    = 1'b0;
  logic [3:0]   cfg_wdata = '0;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata   = '0;   // run, record_key, record_offset, zero pad
  logic         s_tuser   = 1'b0; // action
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [119:0] m_tdata;          // out_key, out_offset, source_run, zero pad
  logic [1:0]   m_tuser;          // status

  merge_state_t         chk_st;
  merge_state_t         gen_st;
  merge_beat_t          pending_beats[$];
  kwsrm_pkg::result_t   merged_q[$];
  merge_beat_t          cur_beat;
  kwsrm_pkg::result_t   want;
  logic [kwsrm_pkg::KEY_W-1:0] run_key[NRUNS];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold     = 1'b0;
  bit hold_arm    = 1'b0;
  int beats_in    = 0;
  int errors      = 0;
  int n_rec       = 0;
  int n_done      = 0;
  int n_rej       = 0;

  kway_sorted_run_merger_top #(.MAX_RUNS(NRUNS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_runs(input logic [kwsrm_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > NRUNS) return NRUNS;
    return int'(v);
  endfunction

  // One input beat against the merge state: reject, wait, emit min or finish.
  function automatic void merge_step(inout merge_state_t st, input merge_beat_t b,
                                     output bit emit, output kwsrm_pkg::result_t r);
    int n;
    int best;
    bit any_full;
    emit     = 1'b1;
    r        = '0;
    any_full = 1'b0;
    best     = 0;
    n        = eff_runs(st.runs);
    if (b.run >= n || st.full[b.run] || st.exh[b.run]) begin
      r.status = kwsrm_pkg::ST_REJECT;
      return;
    end
    if (b.act == kwsrm_pkg::ACT_RECORD) begin
      st.hk[b.run]   = b.key;
      st.ho[b.run]   = b.off;
      st.full[b.run] = 1'b1;
    end else begin
      st.exh[b.run] = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (!st.full[i] && !st.exh[i]) begin
        emit = 1'b0;
        return;
      end
    end
    // strict compares keep the lower run on a full tie
    for (int i = 0; i < n; i++) begin
      if (st.full[i] && (!any_full || st.hk[i] < st.hk[best] ||
          (st.hk[i] == st.hk[best] && st.ho[i] < st.ho[best]))) begin
        best     = i;
        any_full = 1'b1;
      end
    end
    if (any_full) begin
      st.full[best] = 1'b0;
      r.status      = kwsrm_pkg::ST_RECORD;
      r.out_key     = st.hk[best];
      r.out_offset  = st.ho[best];
      r.source_run  = kwsrm_pkg::RUN_W'(best);
    end else begin
      st.full  = '0;
      st.exh   = '0;
      r.status = kwsrm_pkg::ST_DONE;
    end
  endfunction

  function automatic merge_beat_t beat_of(input kwsrm_pkg::action_t a, input int r,
                                          input logic [kwsrm_pkg::KEY_W-1:0] k,
                                          input logic [kwsrm_pkg::OFF_W-1:0] o);
    merge_beat_t b;
    b.act = a;
    b.run = kwsrm_pkg::RUN_W'(r);
    b.key = k;
    b.off = o;
    return b;
  endfunction

  function automatic void new_key_base();
    logic [kwsrm_pkg::KEY_W-1:0] base;
    base = {$urandom, $urandom};
    foreach (run_key[i]) run_key[i] = base;
  endfunction

  // Track what the generator side expects so that sorted sequences follow the
  // run the block names next.
  task automatic queue_beat(input merge_beat_t b);
    bit                 emit;
    kwsrm_pkg::result_t r;
    merge_step(gen_st, b, emit, r);
    if (b.act == kwsrm_pkg::ACT_RECORD && r.status != kwsrm_pkg::ST_REJECT) begin
      run_key[b.run] = b.key;
    end
    if (emit && r.status == kwsrm_pkg::ST_DONE) new_key_base();
    pending_beats = {pending_beats, b};
  endtask

  // Random beats, then a tail of well-formed beats: close the merge when
  // stop_below is 0, else run on until a run below stop_below waits.
  task automatic queue_phase(input int beats, input int stop_below);
    merge_beat_t b;
    int          n;
    int          needy[$];
    bit          tail;
    for (int k = 0; k < beats + 200; k++) begin
      n = eff_runs(gen_st.runs);
      needy.delete();
      for (int i = 0; i < n; i++) begin
        if (!gen_st.full[i] && !gen_st.exh[i]) needy = {needy, i};
      end
      tail = (k >= beats);
      if (tail && stop_below == 0 && gen_st.full == '0 && gen_st.exh == '0) break;
      if (tail && stop_below != 0 && needy.size() != 0 && needy[0] < stop_below) break;
      b.act = kwsrm_pkg::action_t'($urandom_range(1));
      b.run = kwsrm_pkg::RUN_W'($urandom_range(NRUNS - 1));
      b.key = {$urandom, $urandom};
      b.off = kwsrm_pkg::OFF_W'({$urandom, $urandom});
      if (needy.size() != 0 && (tail || $urandom_range(99) >= 15)) begin
        b.run = kwsrm_pkg::RUN_W'(needy[$urandom_range(needy.size() - 1)]);
        if ((tail && stop_below == 0) || $urandom_range(4) == 0) begin
          b.act = kwsrm_pkg::ACT_EXHAUST;
        end else begin
          b.act = kwsrm_pkg::ACT_RECORD;
          // small steps from a shared base give key and offset ties
          if ($urandom_range(7) != 0) begin
            b.key = run_key[b.run] + kwsrm_pkg::KEY_W'($urandom_range(3));
          end
          if ($urandom_range(1) != 0) b.off = kwsrm_pkg::OFF_W'($urandom_range(2));
        end
      end
      queue_beat(b);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_beats.size() != 0 || s_tvalid || merged_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_runs(input logic [kwsrm_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    chk_st.runs = v;
    gen_st.runs = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [kwsrm_pkg::KEY_W-1:0] exp_v,
                             input logic [kwsrm_pkg::KEY_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: predict on each accepted beat, then offer the next one or idle.
  always @(posedge clk) begin : driver
    bit                 emit;
    kwsrm_pkg::result_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        merge_step(chk_st, cur_beat, emit, r);
        if (emit) merged_q = {merged_q, r};
        beats_in++;
      end
      if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        cur_beat = pending_beats.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= cur_beat.act;
        s_tdata  <= {5'd0, cur_beat.off, cur_beat.key, cur_beat.run};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (merged_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual status %h data %h",
                   $time, m_tuser, m_tdata);
        end else begin
          want = merged_q.pop_front();
          check_field("status", kwsrm_pkg::KEY_W'(want.status),
                      kwsrm_pkg::KEY_W'(m_tuser));
          check_field("out_key", want.out_key, m_tdata[63:0]);
          check_field("out_offset", kwsrm_pkg::KEY_W'(want.out_offset),
                      kwsrm_pkg::KEY_W'(m_tdata[111:64]));
          check_field("source_run", kwsrm_pkg::KEY_W'(want.source_run),
                      kwsrm_pkg::KEY_W'(m_tdata[114:112]));
          case (want.status)
            kwsrm_pkg::ST_RECORD: n_rec++;
            kwsrm_pkg::ST_DONE:   n_done++;
            default:              n_rej++;
          endcase
        end
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Hold the output for a long stretch while input keeps coming.
  initial begin
    wait (hold_arm);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    logic [kwsrm_pkg::CFG_W-1:0] cfg_seq[NPHASES];
    bit                          open_seq[NPHASES];
    cfg_seq  = '{4'd1, 4'd8, 4'd0, 4'd4, 4'd15, 4'd3, 4'd9, 4'd8};
    // leave the merge open into the next setting, else close it first
    open_seq = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    chk_st      = '0;
    chk_st.runs = kwsrm_pkg::CFG_W'(kwsrm_pkg::RUNS_RST);
    gen_st      = chk_st;
    new_key_base();
    tx_idle_pct = 33;
    rx_idle_pct = 88;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // two runs from reset: ties, rejects of every kind, two completions
    @(negedge clk);
    queue_beat(beat_of(kwsrm_pkg::ACT_RECORD,  0, '1, '1));
    queue_beat(beat_of(kwsrm_pkg::ACT_RECORD,  0, '0, '0));
    queue_beat(beat_of(kwsrm_pkg::ACT_RECORD,  2, '1, '1));
    queue_beat(beat_of(kwsrm_pkg::ACT_EXHAUST, 7, '1, '1));
    queue_beat(beat_of(kwsrm_pkg::ACT_RECORD,  1, '1, '1));
    queue_beat(beat_of(kwsrm_pkg::ACT_EXHAUST, 1, '0, '0));
    queue_beat(beat_of(kwsrm_pkg::ACT_RECORD,  0, '1, '0));
    queue_beat(beat_of(kwsrm_pkg::ACT_RECORD,  0, '0, '0));
    queue_beat(beat_of(kwsrm_pkg::ACT_EXHAUST, 0, '0, '0));
    queue_beat(beat_of(kwsrm_pkg::ACT_RECORD,  0, '1, '1));
    queue_beat(beat_of(kwsrm_pkg::ACT_EXHAUST, 0, '0, '0));
    queue_beat(beat_of(kwsrm_pkg::ACT_EXHAUST, 1, '0, '0));
    queue_beat(beat_of(kwsrm_pkg::ACT_RECORD,  1, '0, '1));
    queue_beat(beat_of(kwsrm_pkg::ACT_EXHAUST, 0, '1, '1));
    queue_beat(beat_of(kwsrm_pkg::ACT_EXHAUST, 1, '1, '1));
    wait_idle();

    for (int p = 0; p < NPHASES; p++) begin
      write_runs(cfg_seq[p]);
      @(negedge clk);
      if (p < 3) begin
        tx_idle_pct = 33;
        rx_idle_pct = 88;
      end else if (p < 6) begin
        tx_idle_pct = 88;
        rx_idle_pct = 33;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      queue_phase(PHASE_BEATS,
                  (open_seq[p] && p < NPHASES - 1) ? eff_runs(cfg_seq[p + 1]) : 0);
      // stall the output while a full phase of beats is still waiting
      if (p == NPHASES - 1) hold_arm = 1'b1;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("%0d input beats over run counts 2,1,8,0,4,15,3,9,8 with mid-merge changes",
             beats_in);
    $display("checked %0d merged records, %0d completions, %0d rejects",
             n_rec, n_done, n_rej);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
